// ===== sv/cndt_pkg.sv =====
`default_nettype none

package cndt_pkg;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR_SQ = 2'd2;

  // register field widths and limits
  localparam int SIZE_W   = 11;
  localparam int THR_W    = 24;
  localparam int MIN_SIZE = 3;
  localparam int SIZE_RST = 1024;

  // result coordinates
  localparam int COORD_W = 10;

  // direction codes
  localparam int DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_NONE = 3'd0;
  localparam logic [DIR_W-1:0] DIR_ROW  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DIAG = 3'd2;
  localparam logic [DIR_W-1:0] DIR_COL  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_ANTI = 3'd4;

  // tan(22.5 deg) as 27146 / 2^16
  localparam int TAN_W     = 15;
  localparam int TAN_SHIFT = 16;
  localparam logic [TAN_W-1:0] TAN_NUM = 15'd27146;

  // result queue, power of two
  localparam int FIFO_DEPTH = 8;

  // per-stage control
  typedef struct packed {
    logic valid;
    logic report;
  } cndt_ctl_t;

  // decision flags of one centre pixel
  typedef struct packed {
    logic local_max;
    logic above_low;
    logic above_high;
  } cndt_flags_t;

endpackage

`default_nettype wire

// ===== sv/cndt_grad_unit.sv =====
`default_nettype none

module cndt_grad_unit import cndt_pkg::*; #(
  parameter int GRAD_WIDTH = 12
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic signed [GRAD_WIDTH-1:0] grad_x,
  input  logic signed [GRAD_WIDTH-1:0] grad_y,
  output logic [2*GRAD_WIDTH-1:0]     sq_x,
  output logic [2*GRAD_WIDTH-1:0]     sq_y,
  output logic [DIR_W-1:0]            dir
);

  localparam int GW = GRAD_WIDTH;
  localparam int SW = 2 * GW;
  localparam int PW = GW + TAN_SHIFT;

  logic signed [GW-1:0] gx_r;
  logic signed [GW-1:0] gy_r;
  logic signed [SW-1:0] px;
  logic signed [SW-1:0] py;
  logic [GW-1:0]        ax;
  logic [GW-1:0]        ay;
  logic [PW-1:0]        ax_sh;
  logic [PW-1:0]        ay_sh;
  logic [PW-1:0]        kx;
  logic [PW-1:0]        ky;
  logic                 gx_pos;
  logic                 gy_pos;
  logic [DIR_W-1:0]     dir_nxt;
  logic [SW-1:0]        sq_x_r;
  logic [SW-1:0]        sq_y_r;
  logic [DIR_W-1:0]     dir_r;

  // input register, loaded on each accepted beat
  always_ff @(posedge clk) begin
    if (load) begin
      gx_r <= grad_x;
      gy_r <= grad_y;
    end
  end

  // squares of the gradients
  assign px = gx_r * gx_r;
  assign py = gy_r * gy_r;

  // magnitudes and tangent boundary products
  assign ax     = gx_r[GW-1] ? $unsigned(-gx_r) : $unsigned(gx_r);
  assign ay     = gy_r[GW-1] ? $unsigned(-gy_r) : $unsigned(gy_r);
  assign ax_sh  = {ax, {TAN_SHIFT{1'b0}}};
  assign ay_sh  = {ay, {TAN_SHIFT{1'b0}}};
  assign kx     = PW'(TAN_NUM) * PW'(ax);
  assign ky     = PW'(TAN_NUM) * PW'(ay);
  assign gx_pos = !gx_r[GW-1] && (gx_r != '0);
  assign gy_pos = !gy_r[GW-1] && (gy_r != '0);

  // direction quantizer
  always_comb begin
    if (ax == '0 && ay == '0) begin
      dir_nxt = DIR_NONE;
    end else if (ay_sh < kx) begin
      dir_nxt = DIR_ROW;
    end else if (ax_sh < ky) begin
      dir_nxt = DIR_COL;
    end else if (gx_pos == gy_pos) begin
      dir_nxt = DIR_DIAG;
    end else begin
      dir_nxt = DIR_ANTI;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    sq_x_r <= $unsigned(px);
    sq_y_r <= $unsigned(py);
    dir_r  <= dir_nxt;
  end

  assign sq_x = sq_x_r;
  assign sq_y = sq_y_r;
  assign dir  = dir_r;

endmodule

`default_nettype wire

// ===== sv/cndt_line_mem.sv =====
`default_nettype none

module cndt_line_mem import cndt_pkg::*; #(
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 51
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [WIDTH-1:0]  rd_q_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              w2_valid_r;
  logic [ADDR_W-1:0] w2_addr_r;
  logic [WIDTH-1:0]  w2_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // copy of the write that coincided with the read edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_valid_r <= 1'b0;
    end else begin
      w2_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    w2_addr_r <= wr_addr;
    w2_data_r <= wr_data;
  end

  // forwarding: the write in flight wins over the one at the read edge
  always_comb begin
    if (wr_en && wr_addr == rd_addr_r) begin
      rd_data = wr_data;
    end else if (w2_valid_r && w2_addr_r == rd_addr_r) begin
      rd_data = w2_data_r;
    end else begin
      rd_data = rd_q_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cndt_window.sv =====
`default_nettype none

module cndt_window import cndt_pkg::*; #(
  parameter int MAG_W = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift,
  input  logic [MAG_W-1:0]  col_top,
  input  logic [MAG_W-1:0]  col_mid,
  input  logic [MAG_W-1:0]  col_bot,
  input  logic [DIR_W-1:0]  col_dir,
  input  logic [THR_W-1:0]  low_thr,
  input  logic [THR_W-1:0]  high_thr,
  output logic [DIR_W-1:0]  dir_code,
  output cndt_flags_t       flags
);

  localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

  logic [MAG_W-1:0] win_r [9];
  logic [DIR_W-1:0] dd_r  [2];
  logic [MAG_W-1:0] ctr;
  logic [MAG_W-1:0] nb_a;
  logic [MAG_W-1:0] nb_b;
  logic             has_dir;
  logic             lm;

  // 3x3 window and centre direction delay
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      dd_r[0] <= DIR_NONE;
      dd_r[1] <= DIR_NONE;
    end else if (shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= col_top;
      win_r[5] <= col_mid;
      win_r[8] <= col_bot;
      dd_r[0]  <= dd_r[1];
      dd_r[1]  <= col_dir;
    end
  end

  assign ctr = win_r[4];

  // neighbour pair along the quantized axis
  always_comb begin
    has_dir = 1'b1;
    nb_a    = '0;
    nb_b    = '0;
    case (dd_r[0])
      DIR_ROW: begin
        nb_a = win_r[3];
        nb_b = win_r[5];
      end
      DIR_DIAG: begin
        nb_a = win_r[0];
        nb_b = win_r[8];
      end
      DIR_COL: begin
        nb_a = win_r[1];
        nb_b = win_r[7];
      end
      DIR_ANTI: begin
        nb_a = win_r[2];
        nb_b = win_r[6];
      end
      default: begin
        has_dir = 1'b0;
      end
    endcase
  end

  // strict maximum and double threshold
  assign lm               = has_dir && (ctr > nb_a) && (ctr > nb_b);
  assign flags.local_max  = lm;
  assign flags.above_low  = lm && (CMP_W'(ctr) > CMP_W'(low_thr));
  assign flags.above_high = lm && (CMP_W'(ctr) > CMP_W'(high_thr));
  assign dir_code         = dd_r[0];

endmodule

`default_nettype wire

// ===== sv/cndt_out_fifo.sv =====
`default_nettype none

module cndt_out_fifo import cndt_pkg::*; #(
  parameter int WIDTH = 27
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = fifo_r[rd_ptr_r];
  assign cnt_nxt   = cnt_r + CNT_W'(push) - CNT_W'(pop);

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/canny_nonmax_double_threshold.sv =====
// Canny non-maximum suppression with double threshold. Sobel gradient pairs
// arrive one pixel per beat in raster order, column fastest; in_frame_start
// marks pixel (0,0). The block quantizes each gradient into one of four axes,
// keeps the squared magnitudes of the two previous rows and the previous
// row's directions in a single line memory of MAX_DIM words, and for each
// interior pixel reports its position, direction code, whether it is a strict
// maximum along its axis and whether that maximum exceeds the squared low and
// high thresholds. It takes one pixel per clock while in_ready is high. The
// line memory is read when a pixel is accepted and written back from stage
// s2, with forwarding of both pending writes, so any column pattern runs at
// full rate. An eight-entry result queue lets input continue while results
// wait; input stalls only when that queue and the pipeline together are full.
// The line memory needs no clearing after reset. Write the configuration
// registers only while the block is idle; image_size is clamped to the range
// 3 to MAX_DIM.
`default_nettype none

module canny_nonmax_double_threshold import cndt_pkg::*; #(
  parameter int MAX_DIM    = 1024,
  parameter int GRAD_WIDTH = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [GRAD_WIDTH-1:0] in_grad_x,
  input  logic signed [GRAD_WIDTH-1:0] in_grad_y,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COORD_W-1:0]           out_row,
  output logic [COORD_W-1:0]           out_col,
  output logic [DIR_W-1:0]             out_direction_code,
  output logic                         out_local_max,
  output logic                         out_above_low,
  output logic                         out_above_high
);

  localparam int AW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (NW > SIZE_W) ? NW : SIZE_W;
  localparam int MAG_W = 2 * GRAD_WIDTH;
  localparam int LW    = 2 * MAG_W + DIR_W;
  localparam int OUT_W = 2 * COORD_W + DIR_W + 3;
  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);
  localparam int N_RST = (MAX_DIM < SIZE_RST) ? MAX_DIM : SIZE_RST;

  // line word: older row, newer row, newer row direction
  localparam int PREV2_LSB = MAG_W + DIR_W;
  localparam int PREV_LSB  = DIR_W;

  logic [NW-1:0]    n_eff_r;
  logic [THR_W-1:0] low_thr_r;
  logic [THR_W-1:0] high_thr_r;
  logic [CW-1:0]    size_ext;
  logic [NW-1:0]    size_clamp;

  logic [AW-1:0]    row_r;
  logic [AW-1:0]    col_r;
  logic [AW-1:0]    row_nxt;
  logic [AW-1:0]    col_nxt;
  logic [AW-1:0]    cur_row;
  logic [AW-1:0]    cur_col;
  logic [NW-1:0]    row_ext;
  logic [NW-1:0]    col_ext;
  logic [NW-1:0]    row_inc;
  logic [NW-1:0]    col_inc;
  logic             report;
  logic             accept;

  cndt_ctl_t        s1_ctl_r;
  cndt_ctl_t        s2_ctl_r;
  cndt_ctl_t        s3_ctl_r;
  logic [AW-1:0]    s1_row_r;
  logic [AW-1:0]    s1_col_r;
  logic [AW-1:0]    s2_row_r;
  logic [AW-1:0]    s2_col_r;
  logic [AW-1:0]    s3_row_r;
  logic [AW-1:0]    s3_col_r;
  logic [LW-1:0]    s2_line_r;

  logic [LW-1:0]    line_rd;
  logic [LW-1:0]    line_wr;
  logic [MAG_W-1:0] sq_x;
  logic [MAG_W-1:0] sq_y;
  logic [MAG_W-1:0] mag;
  logic [DIR_W-1:0] pix_dir;

  logic [DIR_W-1:0] ctr_dir;
  cndt_flags_t      ctr_flags;
  logic [OUT_W-1:0] push_data;
  logic [OUT_W-1:0] pop_data;
  logic             push;
  logic             drop;
  logic             out_pop;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  // configuration registers
  always_comb begin
    size_ext = CW'(cfg_wdata[SIZE_W-1:0]);
    if (size_ext < CW'(MIN_SIZE)) begin
      size_clamp = NW'(MIN_SIZE);
    end else if (size_ext > CW'(MAX_DIM)) begin
      size_clamp = NW'(MAX_DIM);
    end else begin
      size_clamp = NW'(size_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_eff_r    <= NW'(N_RST);
      low_thr_r  <= '0;
      high_thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_SIZE:  n_eff_r    <= size_clamp;
        REG_LOW_THR_SQ:  low_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_HIGH_THR_SQ: high_thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake against pipeline plus queue occupancy
  assign in_ready = (occ_r < OCC_W'(FIFO_DEPTH));
  assign accept   = in_valid && in_ready;

  // position of the accepted pixel and interior test
  always_comb begin
    cur_row = in_frame_start ? '0 : row_r;
    cur_col = in_frame_start ? '0 : col_r;
    row_ext = NW'(cur_row);
    col_ext = NW'(cur_col);
    row_inc = row_ext + NW'(1);
    col_inc = col_ext + NW'(1);
    report  = (row_ext >= NW'(2)) && (col_ext >= NW'(2)) &&
              (row_ext < n_eff_r) && (col_ext < n_eff_r);
    if (col_inc >= n_eff_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= n_eff_r) ? '0 : AW'(row_inc);
    end else begin
      col_nxt = AW'(col_inc);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      s1_ctl_r.valid  <= accept;
      s1_ctl_r.report <= accept && report;
      s2_ctl_r        <= s1_ctl_r;
      s3_ctl_r        <= s2_ctl_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r <= cur_row;
      s1_col_r <= cur_col;
    end
    s2_row_r  <= s1_row_r;
    s2_col_r  <= s1_col_r;
    s2_line_r <= line_rd;
    s3_row_r  <= s2_row_r;
    s3_col_r  <= s2_col_r;
  end

  // squares and direction, two register stages
  cndt_grad_unit #(
    .GRAD_WIDTH (GRAD_WIDTH)
  ) u_grad (
    .clk    (clk),
    .load   (accept),
    .grad_x (in_grad_x),
    .grad_y (in_grad_y),
    .sq_x   (sq_x),
    .sq_y   (sq_y),
    .dir    (pix_dir)
  );

  // squared magnitude and line word write-back
  assign mag     = sq_x + sq_y;
  assign line_wr = {s2_line_r[PREV_LSB +: MAG_W], mag, pix_dir};

  cndt_line_mem #(
    .ADDR_W (AW),
    .DEPTH  (MAX_DIM),
    .WIDTH  (LW)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (line_rd),
    .wr_en   (s2_ctl_r.valid),
    .wr_addr (s2_col_r),
    .wr_data (line_wr)
  );

  // window and decision
  cndt_window #(
    .MAG_W (MAG_W)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (s2_ctl_r.valid),
    .col_top  (s2_line_r[PREV2_LSB +: MAG_W]),
    .col_mid  (s2_line_r[PREV_LSB +: MAG_W]),
    .col_bot  (mag),
    .col_dir  (s2_line_r[DIR_W-1:0]),
    .low_thr  (low_thr_r),
    .high_thr (high_thr_r),
    .dir_code (ctr_dir),
    .flags    (ctr_flags)
  );

  // result beat into the queue
  assign push      = s3_ctl_r.valid && s3_ctl_r.report;
  assign drop      = s3_ctl_r.valid && !s3_ctl_r.report;
  assign push_data = {COORD_W'(s3_row_r - AW'(1)), COORD_W'(s3_col_r - AW'(1)),
                      ctr_dir, ctr_flags};

  cndt_out_fifo #(
    .WIDTH (OUT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_data)
  );

  assign out_pop = out_valid && out_ready;
  assign {out_row, out_col, out_direction_code,
          out_local_max, out_above_low, out_above_high} = pop_data;

  // beats in flight or queued
  assign occ_nxt = occ_r + OCC_W'(accept) - OCC_W'(out_pop) - OCC_W'(drop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cndt_checker.sv =====
`default_nettype none

module cndt_checker import cndt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [COORD_W-1:0] out_row,
  input wire logic [COORD_W-1:0] out_col,
  input wire logic [DIR_W-1:0]   out_direction_code,
  input wire logic               out_local_max,
  input wire logic               out_above_low,
  input wire logic               out_above_high
);

  // stalled result beat keeps its position, direction and local-maximum flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col) &&
      $stable(out_direction_code) && $stable(out_local_max))
    else $error("result beat changed while stalled");

  // reported pixels are never in row 0 or column 0
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row != '0) && (out_col != '0))
    else $error("border pixel reported");

  // threshold flags require a local maximum
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_local_max |-> !out_above_low && !out_above_high)
    else $error("threshold flag without local maximum");

  // no direction is never a maximum
  a_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_direction_code == DIR_NONE) |-> !out_local_max)
    else $error("local maximum without direction");

  // direction code within the defined axes
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_direction_code <= DIR_ANTI)
    else $error("undefined direction code");

endmodule

bind canny_nonmax_double_threshold cndt_checker u_cndt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_row            (out_row),
  .out_col            (out_col),
  .out_direction_code (out_direction_code),
  .out_local_max      (out_local_max),
  .out_above_low      (out_above_low),
  .out_above_high     (out_above_high)
);

`default_nettype wire
